>>> src/otft_pkg.sv
// Shared types and constants for the owner texture frequency table.
package otft_pkg;

  localparam int CFG_IDX_W = 8;
  localparam int RESULT_CAP = 4;
  localparam logic [15:0] STALE_RESET = 16'd120;
  localparam logic [15:0] LIVE_RESET = 16'd4;
  localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;
  localparam logic [7:0] ROW_SIDES = 8'd32;

  typedef enum logic [2:0] {
    CMD_DRAW  = 3'd0,
    CMD_TICK  = 3'd1,
    CMD_SIDE  = 3'd2,
    CMD_OWNER = 3'd3,
    CMD_CLEAR = 3'd4
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STALE = 8'd0,
    CFG_LIVE  = 8'd1
  } cfg_e;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [63:0] owner_id;
    logic [63:0] texture_id;
    logic [7:0]  side_num;
    logic        paused;
    logic [4:0]  limit;
  } in_t;

  typedef struct packed {
    logic        found;
    logic        is_live;
    logic [63:0] chosen_texture;
    logic [31:0] row_mask;
    logic [63:0] owner_out;
    logic [7:0]  side_out;
    logic [63:0] candidate;
    logic [4:0]  entry_count;
    logic [31:0] tick_count;
    logic        last;
  } out_t;

  typedef struct packed {
    logic [63:0] owner;
    logic [63:0] choice;
    logic [31:0] rows;
    logic [7:0]  side;
    logic [31:0] seen;
    logic [31:0] draws;
  } entry_t;

  typedef struct packed {
    logic [63:0] texture;
    logic [31:0] draws;
    logic [31:0] seen;
  } slot_t;

  function automatic logic ent_is_live(entry_t e, logic [31:0] now, logic [15:0] lim);
    logic [31:0] age;
    age = now - e.seen;
    return (e.choice != 64'd0) && (age <= {16'd0, lim});
  endfunction

endpackage

>>> src/otft_ram.sv
// Generic single-write, single-read RAM with registered read data.
module otft_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

>>> src/otft_slot_unit.sv
// Slot row logic: frequent-items count update and ranked best-slot pick.
module otft_slot_unit import otft_pkg::*; #(
  parameter int SLOTS = 4,
  localparam int SIW = (SLOTS > 1) ? $clog2(SLOTS) : 1,
  localparam int NW = $clog2(SLOTS + 1)
) (
  input  slot_t [SLOTS-1:0] row_i,
  input  logic [63:0]       tex_i,
  input  logic [31:0]       now_i,
  input  logic [15:0]       live_lim_i,
  input  logic [SLOTS-1:0]  taken_i,
  output slot_t [SLOTS-1:0] row_o,
  output logic              best_vld_o,
  output logic [SIW-1:0]    best_idx_o,
  output logic [63:0]       best_tex_o,
  output logic              more_o
);

  logic [SLOTS-1:0] live;
  logic             hit, fh, bl;
  logic [SIW-1:0]   hidx, fidx, widx, bi;
  logic [31:0]      wd, bd;
  logic [NW-1:0]    cnt;

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      live[i] = (row_i[i].texture != 64'd0) &&
                ((now_i - row_i[i].seen) <= {16'd0, live_lim_i});
    end
  end

  always_comb begin
    hit = 1'b0;
    hidx = '0;
    fh = 1'b0;
    fidx = '0;
    widx = '0;
    wd = row_i[0].draws;
    for (int i = 0; i < SLOTS; i++) begin
      if (!hit && row_i[i].texture == tex_i) begin
        hit = 1'b1;
        hidx = SIW'(i);
      end
      if (!fh && !live[i]) begin
        fh = 1'b1;
        fidx = SIW'(i);
      end
      if (row_i[i].draws < wd) begin
        wd = row_i[i].draws;
        widx = SIW'(i);
      end
    end
    row_o = row_i;
    if (hit) begin
      if (row_i[hidx].draws != SAT32) row_o[hidx].draws = row_i[hidx].draws + 32'd1;
      row_o[hidx].seen = now_i;
    end else if (fh) begin
      row_o[fidx] = '{texture: tex_i, draws: 32'd1, seen: now_i};
    end else if (wd <= 32'd1) begin
      row_o[widx] = '{texture: tex_i, draws: 32'd1, seen: now_i};
    end else begin
      row_o[widx].draws = wd - 32'd1;
    end
  end

  // Rank: live first, then higher count, then lower index.
  always_comb begin
    best_vld_o = 1'b0;
    bi = '0;
    bl = 1'b0;
    bd = '0;
    cnt = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (row_i[i].texture != 64'd0 && !taken_i[i]) begin
        cnt = cnt + NW'(1);
        if (!best_vld_o || ((live[i] != bl) ? live[i] : (row_i[i].draws > bd))) begin
          best_vld_o = 1'b1;
          bi = SIW'(i);
          bl = live[i];
          bd = row_i[i].draws;
        end
      end
    end
    best_idx_o = bi;
    best_tex_o = row_i[bi].texture;
    more_o = cnt > NW'(1);
  end

endmodule

>>> src/owner_texture_frequency_table_unit.sv
// Owner texture frequency table: top level with command sequencer and table memories.
// A paused tick, clear or ignored command goes straight to its result; otherwise held entries
// are scanned (memory read, then check), stopping at an owner match for a draw or owner query.
// An owner query then emits one result per cycle while the output is not stalled, up to
// min(limit, 4, SLOTS) results. No new transaction is accepted until the current one ends.
// Reset empties the table (fill count to zero), clears the tick and loads 120 / 4 limits.
module owner_texture_frequency_table_unit import otft_pkg::*; #(
  parameter int MAX_ENTRIES = 16,
  parameter int SLOTS = 4,
  parameter int SIDE_COUNT = 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_t                  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_t                 out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [15:0]          cfg_data_i
);

  localparam int IdxW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CntW = $clog2(MAX_ENTRIES + 1);
  localparam int SIW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int EntW = $bits(entry_t);
  localparam int RowW = SLOTS * $bits(slot_t);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_SCAN  = 8'b0000_0010,
    S_CHK   = 8'b0000_0100,
    S_UPD   = 8'b0000_1000,
    S_WRITE = 8'b0001_0000,
    S_RANK  = 8'b0010_0000,
    S_SIDE  = 8'b0100_0000,
    S_ZERO  = 8'b1000_0000
  } state_e;

  state_e st_q, st_d;
  in_t item_q;
  logic [CntW-1:0] idx_q, wr_q, count_q;
  logic [IdxW-1:0] hit_idx_q;
  logic [31:0] tick_q;
  logic [15:0] stale_q, live_q;
  entry_t ent_q, bl_q, ba_q, rd_ent, ent_w, ent_upd;
  slot_t [SLOTS-1:0] row_q, rd_row, new_row;
  logic bl_vld_q, ba_vld_q;
  logic [SLOTS-1:0] taken_q;
  logic [4:0] ncand_q, maxn;
  out_t out_q, out_d;
  logic out_vld_q, out_free, emit;

  logic ent_we, row_we;
  logic [IdxW-1:0] waddr, raddr;
  logic [EntW-1:0] ent_wdata, ent_rdata;
  logic [RowW-1:0] row_wdata, row_rdata;

  logic best_vld, more;
  logic [SIW-1:0] best_idx;
  logic [63:0] best_tex;
  logic scan_end, own_hit, keep, ent_live, last_cand;
  logic [CntW+4:0] count_ext;

  otft_ram #(.WIDTH(EntW), .DEPTH(MAX_ENTRIES)) u_ent_ram (
    .clk_i, .we_i(ent_we), .waddr_i(waddr), .wdata_i(ent_wdata),
    .raddr_i(raddr), .rdata_o(ent_rdata)
  );

  otft_ram #(.WIDTH(RowW), .DEPTH(MAX_ENTRIES)) u_row_ram (
    .clk_i, .we_i(row_we), .waddr_i(waddr), .wdata_i(row_wdata),
    .raddr_i(raddr), .rdata_o(row_rdata)
  );

  otft_slot_unit #(.SLOTS(SLOTS)) u_slot (
    .row_i(row_q), .tex_i(item_q.texture_id), .now_i(tick_q), .live_lim_i(live_q),
    .taken_i(taken_q), .row_o(new_row), .best_vld_o(best_vld), .best_idx_o(best_idx),
    .best_tex_o(best_tex), .more_o(more)
  );

  assign rd_ent = ent_rdata;
  assign rd_row = row_rdata;
  assign raddr = idx_q[IdxW-1:0];
  assign scan_end = (idx_q == count_q);
  assign own_hit = (rd_ent.owner == item_q.owner_id);
  assign keep = ((tick_q - rd_ent.seen) <= {16'd0, stale_q});
  assign ent_live = ent_is_live(ent_q, tick_q, live_q);
  assign count_ext = {5'd0, count_q};

  always_comb begin
    ent_w = ent_q;
    ent_w.choice = best_vld ? best_tex : 64'd0;
  end

  always_comb begin
    ent_upd = ent_q;
    ent_upd.side = item_q.side_num;
    if (item_q.side_num < ROW_SIDES) begin
      ent_upd.rows = ent_q.rows | (32'd1 << item_q.side_num[4:0]);
    end
    ent_upd.seen = tick_q;
    if (ent_q.draws != SAT32) ent_upd.draws = ent_q.draws + 32'd1;
  end

  // Compaction writes in the check state; the draw writes back in the write state.
  always_comb begin
    ent_we = 1'b0;
    waddr = hit_idx_q;
    ent_wdata = ent_w;
    row_wdata = row_q;
    if (st_q == S_CHK && cmd_e'(item_q.cmd) == CMD_TICK) begin
      ent_we = keep && (wr_q != idx_q);
      waddr = wr_q[IdxW-1:0];
      ent_wdata = rd_ent;
      row_wdata = rd_row;
    end else if (st_q == S_WRITE) begin
      ent_we = 1'b1;
    end
    row_we = ent_we;
  end

  always_comb begin
    maxn = (item_q.limit > 5'(RESULT_CAP)) ? 5'(RESULT_CAP) : item_q.limit;
    if (maxn > 5'(SLOTS)) maxn = 5'(SLOTS);
  end

  assign last_cand = (ncand_q + 5'd1 == maxn) || !more;
  assign out_free = !out_vld_q || !out_stall_i;

  always_comb begin
    emit = 1'b0;
    out_d = '0;
    out_d.entry_count = count_ext[4:0];
    out_d.tick_count = tick_q;
    out_d.last = 1'b1;
    case (st_q)
      S_ZERO: emit = out_free;
      S_SIDE: begin
        emit = out_free;
        if (bl_vld_q || ba_vld_q) begin
          out_d.found = 1'b1;
          out_d.is_live = bl_vld_q;
          out_d.chosen_texture = bl_vld_q ? bl_q.choice : ba_q.choice;
          out_d.row_mask = bl_vld_q ? bl_q.rows : ba_q.rows;
          out_d.owner_out = bl_vld_q ? bl_q.owner : ba_q.owner;
          out_d.side_out = bl_vld_q ? bl_q.side : ba_q.side;
        end
      end
      S_WRITE: begin
        emit = out_free;
        out_d.found = 1'b1;
        out_d.is_live = ent_is_live(ent_w, tick_q, live_q);
        out_d.chosen_texture = ent_w.choice;
        out_d.row_mask = ent_w.rows;
        out_d.owner_out = ent_w.owner;
        out_d.side_out = ent_w.side;
      end
      S_RANK: begin
        emit = out_free;
        out_d.found = 1'b1;
        out_d.owner_out = ent_q.owner;
        out_d.side_out = ent_q.side;
        out_d.is_live = ent_live;
        out_d.chosen_texture = ent_live ? ent_q.choice : 64'd0;
        out_d.row_mask = ent_live ? ent_q.rows : 32'd0;
        if (ent_live && maxn != 5'd0 && best_vld) begin
          out_d.candidate = best_tex;
          out_d.last = last_cand;
        end
      end
      default: emit = 1'b0;
    endcase
  end

  always_comb begin
    st_d = st_q;
    case (st_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (cmd_e'(in_data_i.cmd))
            CMD_DRAW: st_d = (in_data_i.owner_id == 64'd0 || in_data_i.texture_id == 64'd0)
                             ? S_ZERO : S_SCAN;
            CMD_TICK: st_d = in_data_i.paused ? S_ZERO : S_SCAN;
            CMD_SIDE: st_d = ({1'b0, in_data_i.side_num} < 9'(SIDE_COUNT)) ? S_SCAN : S_ZERO;
            CMD_OWNER: st_d = (in_data_i.owner_id == 64'd0) ? S_ZERO : S_SCAN;
            default: st_d = S_ZERO;
          endcase
        end
      end
      S_SCAN: begin
        if (!scan_end) begin
          st_d = S_CHK;
        end else begin
          case (cmd_e'(item_q.cmd))
            CMD_DRAW: st_d = (count_q >= CntW'(MAX_ENTRIES)) ? S_ZERO : S_UPD;
            CMD_SIDE: st_d = S_SIDE;
            default: st_d = S_ZERO;
          endcase
        end
      end
      S_CHK: begin
        st_d = S_SCAN;
        if (own_hit && cmd_e'(item_q.cmd) == CMD_DRAW) st_d = S_UPD;
        if (own_hit && cmd_e'(item_q.cmd) == CMD_OWNER) st_d = S_RANK;
      end
      S_UPD: st_d = S_WRITE;
      S_WRITE, S_SIDE, S_ZERO: if (out_free) st_d = S_IDLE;
      S_RANK: if (out_free && out_d.last) st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
      count_q <= '0;
      tick_q <= '0;
      stale_q <= STALE_RESET;
      live_q <= LIVE_RESET;
      out_vld_q <= 1'b0;
      idx_q <= '0;
      wr_q <= '0;
      bl_vld_q <= 1'b0;
      ba_vld_q <= 1'b0;
      taken_q <= '0;
      ncand_q <= '0;
    end else begin
      st_q <= st_d;
      if (cfg_valid_i && cfg_index_i == CFG_STALE) stale_q <= cfg_data_i;
      if (cfg_valid_i && cfg_index_i == CFG_LIVE) live_q <= cfg_data_i;
      if (emit) out_vld_q <= 1'b1;
      else if (!out_stall_i) out_vld_q <= 1'b0;
      case (st_q)
        S_IDLE: begin
          idx_q <= '0;
          wr_q <= '0;
          bl_vld_q <= 1'b0;
          ba_vld_q <= 1'b0;
          taken_q <= '0;
          ncand_q <= '0;
          if (in_valid_i) begin
            if (cmd_e'(in_data_i.cmd) == CMD_TICK && !in_data_i.paused) tick_q <= tick_q + 32'd1;
            if (cmd_e'(in_data_i.cmd) == CMD_CLEAR) count_q <= '0;
          end
        end
        S_SCAN: begin
          if (scan_end && cmd_e'(item_q.cmd) == CMD_TICK) count_q <= wr_q;
          if (scan_end && cmd_e'(item_q.cmd) == CMD_DRAW && count_q < CntW'(MAX_ENTRIES)) begin
            count_q <= count_q + CntW'(1);
          end
        end
        S_CHK: begin
          idx_q <= idx_q + CntW'(1);
          if (cmd_e'(item_q.cmd) == CMD_TICK && keep) wr_q <= wr_q + CntW'(1);
          if (cmd_e'(item_q.cmd) == CMD_SIDE && rd_ent.side == item_q.side_num &&
              rd_ent.choice != 64'd0) begin
            if (!ba_vld_q || rd_ent.draws > ba_q.draws) ba_vld_q <= 1'b1;
            if (ent_is_live(rd_ent, tick_q, live_q) &&
                (!bl_vld_q || rd_ent.draws > bl_q.draws)) bl_vld_q <= 1'b1;
          end
        end
        S_RANK: begin
          if (out_free && best_vld && ent_live && maxn != 5'd0) begin
            taken_q <= taken_q | (SLOTS'(1) << best_idx);
            ncand_q <= ncand_q + 5'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (emit) out_q <= out_d;
    if (st_q == S_IDLE && in_valid_i) item_q <= in_data_i;
    case (st_q)
      S_SCAN: begin
        if (scan_end) begin
          hit_idx_q <= idx_q[IdxW-1:0];
          ent_q <= '{owner: item_q.owner_id, default: '0};
          row_q <= '0;
        end
      end
      S_CHK: begin
        if (own_hit) begin
          hit_idx_q <= idx_q[IdxW-1:0];
          ent_q <= rd_ent;
          row_q <= rd_row;
        end
        if (rd_ent.side == item_q.side_num && rd_ent.choice != 64'd0) begin
          if (!ba_vld_q || rd_ent.draws > ba_q.draws) ba_q <= rd_ent;
          if (ent_is_live(rd_ent, tick_q, live_q) &&
              (!bl_vld_q || rd_ent.draws > bl_q.draws)) bl_q <= rd_ent;
        end
      end
      S_UPD: begin
        ent_q <= ent_upd;
        row_q <= new_row;
      end
      S_WRITE: ent_q <= ent_w;
      default: ;
    endcase
  end

  assign in_stall_o = (st_q != S_IDLE);
  assign out_valid_o = out_vld_q;
  assign out_data_o = out_q;
  assign cfg_ready_o = 1'b1;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MAX_ENTRIES))
    else $error("entry count exceeds table depth");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_SCAN || st_q == S_CHK) |-> idx_q <= count_q)
    else $error("scan index beyond held entries");

  a_compact_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_q <= idx_q)
    else $error("compaction write pointer ahead of read pointer");

  a_rank_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == S_RANK |-> $countones(taken_q) == 32'(ncand_q))
    else $error("taken mask disagrees with candidate count");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_stall_i) |=> $stable(out_q))
    else $error("held result overwritten");

endmodule
